FILE: rtl/core/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_W  = 8;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } code_entry_t;

endpackage

FILE: rtl/core/huffman_code_bit_packer.sv
// Table-driven Huffman encoder with a byte packer.
// Input channel (s_valid/s_ready): one transfer carries a command. A load
// writes the code word and length of s_symbol into the code table. An encode
// reads the symbol's entry into a read register and then moves its bits,
// first bit first, into an 8-bit accumulator; each step of the shifter moves
// as many bits as fit the accumulator.
// A flush pads pending bits with zeros on the low end and emits that byte.
// Result channel (m_valid/m_ready): one transfer per packed byte, earliest bit
// in the MSB; m_last marks the final byte that an input transfer produces.
// A byte of an encode passes the table read register and the shifter before the output register puts it on m_valid.
// s_ready is high only while the sequencer is idle; the result sits in an
// output register, so a new item is taken while a byte still waits there.
// When the receiver stalls with a full byte pending, the shifter holds.
// Reset clears the accumulator and the output valid flag; the code table is not
// cleared, and an entry must be loaded before its symbol is encoded.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [SYM_W-1:0]  s_symbol,
    input  logic [CODE_W-1:0] s_code_word,
    input  logic [LEN_W-1:0]  s_code_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_last
);

    localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_BOUND = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ROOM_W    = CNT_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    code_entry_t code_table [SYMBOL_COUNT];
    code_entry_t rd_entry_reg;

    logic [1:0]        state_reg, state_next;
    logic [BYTE_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    logic              sym_ok;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  load_len;
    logic              out_free;

    // encode shifter
    logic [ROOM_W-1:0] room;
    logic [ROOM_W-1:0] take;
    logic [LEN_W-1:0]  rem_after;
    logic [CODE_W-1:0] shifted;
    logic [BYTE_W-1:0] chunk_mask;
    logic [BYTE_W-1:0] chunk;
    logic [BYTE_W-1:0] pend_merged;
    logic [ROOM_W-1:0] cnt_sum;
    logic              full;
    logic              step;
    logic [BYTE_W-1:0] flush_byte;

    assign accept   = s_valid && s_ready;
    assign sym_ok   = ({1'b0, s_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign addr     = s_symbol[ADDR_W-1:0];
    assign load_len = (s_code_length > LEN_W'(LEN_BOUND)) ? LEN_W'(LEN_BOUND)
                                                          : s_code_length;
    assign out_free = !m_valid_reg || m_ready;

    // take as many code bits as the accumulator has room for
    assign room        = ROOM_W'(BYTE_W) - {1'b0, cnt_reg};
    assign take        = ({{(LEN_W-ROOM_W){1'b0}}, room} < rem_reg) ? room
                                                                    : ROOM_W'(rem_reg);
    assign rem_after   = rem_reg - LEN_W'(take);
    assign shifted     = rd_entry_reg.bits >> rem_after;
    assign chunk_mask  = BYTE_W'((9'd1 << take) - 9'd1);
    assign chunk       = shifted[BYTE_W-1:0] & chunk_mask;
    assign pend_merged = BYTE_W'({8'b0, pend_reg} << take) | chunk;
    assign cnt_sum     = {1'b0, cnt_reg} + take;
    assign full        = (cnt_sum == ROOM_W'(BYTE_W));
    assign step        = (state_reg == ST_SHIFT) && (!full || out_free);
    assign flush_byte  = BYTE_W'({8'b0, pend_reg} << (ROOM_W'(BYTE_W) - {1'b0, cnt_reg}));

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

    // code table: write on load, registered read on encode
    always_ff @(posedge aclk) begin
        if (accept && s_command == CMD_LOAD && sym_ok) begin
            code_table[addr] <= '{bits: s_code_word, len: load_len};
        end
        if (accept && s_command == CMD_ENCODE) begin
            rd_entry_reg <= code_table[addr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_ENCODE: begin
                            if (sym_ok) begin
                                state_next = ST_READ;
                            end
                        end
                        CMD_FLUSH: begin
                            if (cnt_reg != '0) begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                rem_next   = rd_entry_reg.len;
                state_next = (rd_entry_reg.len == '0) ? ST_IDLE : ST_SHIFT;
            end
            ST_SHIFT: begin
                if (step) begin
                    rem_next = rem_after;
                    if (full) begin
                        pend_next    = '0;
                        cnt_next     = '0;
                        m_valid_next = 1'b1;
                        m_byte_next  = pend_merged;
                        m_last_next  = (rem_after < LEN_W'(BYTE_W));
                    end else begin
                        pend_next = pend_merged;
                        cnt_next  = cnt_sum[CNT_W-1:0];
                    end
                    if (rem_after == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    pend_next    = '0;
                    cnt_next     = '0;
                    m_valid_next = 1'b1;
                    m_byte_next  = flush_byte;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

`ifndef ASSERT_OFF
    a_shift_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (rem_reg != '0))
        else $error("shifter active with no code bits left");

    a_partial_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !full) |=> (state_reg == ST_IDLE))
        else $error("partial byte step was not the final step of the code");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && out_free) |=> (cnt_reg == '0 && m_valid && m_last))
        else $error("flush did not emit a last byte and clear the accumulator");

    a_encode_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_ENCODE && sym_ok) |=> (state_reg == ST_READ))
        else $error("encode transfer did not start a table read");
`endif

endmodule

FILE: tb/tb_huffman_code_bit_packer.sv
`default_nettype none

module tb_huffman_code_bit_packer;
    import hcbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command 3 has no meaning in the block; it is accepted and dropped.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 154;
    localparam int DRAIN_POINT  = 90;
    localparam int TAIL_CYCLES  = 40;
    localparam int DRAIN_LIMIT  = 5000;

    // One stimulus item. Rows with has_typed set carry their expected bytes
    // inline (typed_count bytes, MSB first in typed_bytes); all others are
    // checked against the packer model below.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        bit                has_typed;
        int                typed_count;
        logic [31:0]       typed_bytes;
    } stim_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    // Directed rows: extremes of code length and word, overlong and zero
    // length codes, empty and partial flushes, the unused command, codes that
    // straddle byte boundaries, and an entry that is written over.
    localparam int DIRECTED_ROWS = 26;
    localparam stim_item_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
        '{CMD_LOAD,   8'd0,   32'h0000_00FF, 6'd8,  1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 1, 32'hFF00_0000},
        '{CMD_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd255, 32'h0000_0000, 6'd0,  1'b1, 4, 32'hFFFF_FFFF},
        '{CMD_LOAD,   8'd1,   32'h0000_0001, 6'd1,  1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b1, 1, 32'h8000_0000},
        '{CMD_FLUSH,  8'd77,  32'hFFFF_FFFF, 6'd63, 1'b1, 0, 32'h0000_0000},
        '{CMD_LOAD,   8'd2,   32'hAAAA_AAAA, 6'd63, 1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b1, 4, 32'hAAAA_AAAA},
        '{CMD_LOAD,   8'd3,   32'h1234_5678, 6'd0,  1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd3,   32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
        '{CMD_UNUSED, 8'hA5,  32'hDEAD_BEEF, 6'd42, 1'b1, 0, 32'h0000_0000},
        '{CMD_LOAD,   8'd4,   32'h0000_0005, 6'd3,  1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd4,   32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd255, 32'h5555_5555, 6'd21, 1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd2,   32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
        '{CMD_FLUSH,  8'd0,   32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
        '{CMD_LOAD,   8'd128, 32'h0000_0000, 6'd7,  1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd128, 32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd1,   32'h0000_0000, 6'd0,  1'b1, 1, 32'h0100_0000},
        '{CMD_LOAD,   8'd5,   32'hFFFF_FFFF, 6'd33, 1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd5,   32'h0000_0000, 6'd0,  1'b1, 4, 32'hFFFF_FFFF},
        '{CMD_LOAD,   8'd0,   32'h0000_0000, 6'd32, 1'b0, 0, 32'h0000_0000},
        '{CMD_ENCODE, 8'd0,   32'h0000_0000, 6'd0,  1'b1, 4, 32'h0000_0000}
    };

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command     = CMD_LOAD;
    logic [SYM_W-1:0]  s_symbol      = '0;
    logic [CODE_W-1:0] s_code_word   = '0;
    logic [LEN_W-1:0]  s_code_length = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last;

    huffman_code_bit_packer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_symbol      (s_symbol),
        .s_code_word   (s_code_word),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Packer model: its own copy of the code table and the accumulator.
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] tbl_code   [SYMBOL_COUNT_DEF];
    logic [LEN_W-1:0]  tbl_len    [SYMBOL_COUNT_DEF];
    bit                tbl_loaded [SYMBOL_COUNT_DEF];
    logic [SYM_W-1:0]  loaded_syms [$];
    logic [BYTE_W-1:0] acc_bits  = '0;
    int                acc_count = 0;

    packed_byte_t      awaited_bytes [$];
    int                fail_count = 0;

    // Work out the bytes one accepted transfer produces and advance the model.
    function automatic void pack_transfer(input stim_item_t it,
                                          ref packed_byte_t produced [$]);
        int           bound;
        int           clen;
        packed_byte_t pb;
        bound = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
        produced.delete();
        case (it.cmd)
            CMD_LOAD: begin
                // Saturate an overlong code to the word width.
                tbl_code[it.sym] = it.word;
                tbl_len[it.sym]  = (int'(it.len) > bound) ? LEN_W'(bound) : it.len;
                if (!tbl_loaded[it.sym]) begin
                    tbl_loaded[it.sym] = 1'b1;
                    loaded_syms.push_back(it.sym);
                end
            end
            CMD_ENCODE: begin
                clen = int'(tbl_len[it.sym]);
                // Shift the first code bit (at clen-1) in first.
                for (int i = clen; i > 0; i--) begin
                    acc_bits = {acc_bits[BYTE_W-2:0], tbl_code[it.sym][i-1]};
                    acc_count++;
                    if (acc_count == BYTE_W) begin
                        pb.data = acc_bits;
                        pb.last = 1'b0;
                        produced.push_back(pb);
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                end
                if (produced.size() > 0) begin
                    produced[produced.size()-1].last = 1'b1;
                end
            end
            CMD_FLUSH: begin
                // Pad the pending bits with zeros on the low end.
                if (acc_count != 0) begin
                    pb.data = acc_bits << (BYTE_W - acc_count);
                    pb.last = 1'b1;
                    produced.push_back(pb);
                    acc_bits  = '0;
                    acc_count = 0;
                end
            end
            default: begin
                // Unused command: drop it.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    bit tx_burst = 1'b0;

    // Present one item and hold it until the transfer. Called in the time
    // step of the previous transfer, so s_valid is lowered only when a gap or
    // a drain follows; otherwise the valid stays high into the next item.
    task automatic send_item(input stim_item_t it, input bit drain);
        int           gap;
        packed_byte_t produced [$];
        packed_byte_t pb;
        if (tx_burst) begin
            gap = 0;
        end else begin
            gap = $urandom_range(0, 9);
        end
        if (drain || gap > 0) begin
            s_valid <= 1'b0;
            if (drain) begin
                // Hold off until every awaited byte has come back.
                do @(posedge aclk); while (awaited_bytes.size() != 0);
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= it.cmd;
        s_symbol      <= it.sym;
        s_code_word   <= it.word;
        s_code_length <= it.len;
        do @(posedge aclk); while (!s_ready);
        // Transfer taken at this edge: advance the model, queue the bytes.
        pack_transfer(it, produced);
        if (it.has_typed) begin
            for (int k = 0; k < it.typed_count; k++) begin
                pb.data = it.typed_bytes[31 - 8*k -: 8];
                pb.last = (k == it.typed_count - 1);
                awaited_bytes.push_back(pb);
            end
        end else begin
            foreach (produced[k]) awaited_bytes.push_back(produced[k]);
        end
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    endtask

    // Draw one random item; most are loads and encodes of loaded symbols.
    function automatic stim_item_t random_item();
        stim_item_t it;
        int         pick;
        int         lpick;
        pick = $urandom_range(0, 99);
        it.sym         = SYM_W'($urandom_range(0, 255));
        it.word        = $urandom;
        it.len         = LEN_W'($urandom_range(0, 63));
        it.has_typed   = 1'b0;
        it.typed_count = 0;
        it.typed_bytes = '0;
        if (loaded_syms.size() == 0 || pick < 22) begin
            it.cmd = CMD_LOAD;
            lpick  = $urandom_range(0, 99);
            if (lpick < 5) begin
                it.len = '0;
            end else if (lpick < 80) begin
                it.len = LEN_W'($urandom_range(1, 12));
            end else if (lpick < 93) begin
                it.len = LEN_W'($urandom_range(13, 32));
            end else begin
                it.len = LEN_W'($urandom_range(33, 63));
            end
        end else if (pick < 82) begin
            // Only symbols with a loaded entry are ever encoded.
            it.cmd = CMD_ENCODE;
            it.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end else if (pick < 96) begin
            it.cmd = CMD_FLUSH;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stall per byte, then compare with the oldest
    // awaited byte.
    // ------------------------------------------------------------------
    int rx_wait  = 0;
    bit rx_burst = 1'b0;

    always @(posedge aclk) begin
        int           w;
        packed_byte_t exp_b;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (awaited_bytes.size() == 0) begin
                $error("out_byte: expected none, got %02h (last %0b)", m_out_byte, m_last);
                fail_count++;
            end else begin
                exp_b = awaited_bytes.pop_front();
                if (m_out_byte !== exp_b.data) begin
                    $error("out_byte: expected %02h, got %02h", exp_b.data, m_out_byte);
                    fail_count++;
                end
                if (m_last !== exp_b.last) begin
                    $error("last: expected %0b, got %0b", exp_b.last, m_last);
                    fail_count++;
                end
            end
            if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
            w = rx_burst ? 0 : $urandom_range(0, 9);
            if (w == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_wait <= w;
            end
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            if (rx_wait == 1) m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int sent;
        int spin;
        stim_item_t it;
        sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_item(DIRECTED[r], 1'b0);
        end

        // Random part; pause once for a full drain before random item DRAIN_POINT.
        while (sent < RANDOM_ITEMS) begin
            it = random_item();
            send_item(it, sent == DRAIN_POINT);
            sent++;
        end
        s_valid <= 1'b0;

        // Let the last bytes come back, then watch for strays.
        spin = 0;
        while (awaited_bytes.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge aclk);
            spin++;
        end
        if (awaited_bytes.size() != 0) begin
            $error("out_byte: %0d awaited bytes never came", awaited_bytes.size());
            fail_count++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
